// ===== design/job_slot_dispatcher_defines.svh =====
// Assertion helpers for the job slot dispatcher.
`ifndef JOB_SLOT_DISPATCHER_DEFINES_SVH
`define JOB_SLOT_DISPATCHER_DEFINES_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define JSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true.
`define JSD_NEVER(lbl, clk, rst_n, cond, msg) \
    `JSD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== design/jsd_pkg.sv =====
`timescale 1ns / 1ps
package jsd_pkg;

    localparam int ID_W    = 16;
    localparam int CORE_W  = 3;
    localparam int CNT_OUT = 7;
    localparam int MAX_WRK = 8;

    typedef enum logic [2:0] {
        ACT_SUBMIT   = 3'd0,
        ACT_CLAIM    = 3'd1,
        ACT_COMPLETE = 3'd2,
        ACT_CANCEL   = 3'd3,
        ACT_QUERY    = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_EMPTY   = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_RUNNING = 3'd2,
        ST_DONE    = 3'd3,
        ST_FAILED  = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CFG_ENABLE      = 1'b0,
        CFG_WORKER_MASK = 1'b1
    } t_cfg_reg;

    localparam logic [1:0] RC_OK     = 2'd0;
    localparam logic [1:0] RC_REJECT = 2'd1;
    localparam logic [1:0] RC_NOWRK  = 2'd2;
    localparam logic [1:0] RC_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]        action;
        logic [ID_W-1:0]   job_id;
        logic [CORE_W-1:0] core;
        logic              has_function;
        logic              require_remote;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_code;
        logic [ID_W-1:0]    job_id_out;
        logic [CORE_W-1:0]  picked_core;
        logic [2:0]         job_status;
        logic [CNT_OUT-1:0] queued_count;
        logic [CNT_OUT-1:0] running_count;
    } t_out_item;

    typedef struct packed {
        logic              go_submit;
        logic              go_claim;
        logic              go_complete;
        logic              go_cancel;
        logic              has_function;
        logic [ID_W-1:0]   job_id;
        logic [CORE_W-1:0] core;
        logic [ID_W-1:0]   new_id;
        logic [CORE_W-1:0] new_owner;
    } t_ctl;

    typedef struct packed {
        logic              free_hit;
        logic              claim_hit;
        logic [ID_W-1:0]   claim_id;
        logic              find_hit;
        t_status           find_status;
        logic [CORE_W-1:0] find_owner;
    } t_link;

endpackage

// ===== design/job_slot_dispatcher.sv =====
`timescale 1ns / 1ps
// The request is registered at the accepting edge, the table is evaluated while busy,
// and the result is registered from it. The input stalls while an item is in evaluation
// or its result has not been taken. The slot search is one ripple through the cell row.
// Reset (synchronous, active low): all slots empty, next id one, round robin and
// counts zero, enable and worker mask zero. No clearing pass is needed.
module job_slot_dispatcher import jsd_pkg::*; #(
    parameter int NUM_SLOTS = 64,
    parameter int NUM_CORES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    `include "job_slot_dispatcher_defines.svh"

    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic              r_enable;
    logic [7:0]        r_mask;
    logic              r_busy;
    t_in_item          r_req;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic [2:0]        r_rr, n_rr;
    logic [CW-1:0]     r_qcnt, n_qcnt, r_rcnt, n_rcnt;

    t_ctl              ctl;
    t_link             links [NUM_SLOTS+1];
    t_link             last;
    logic [7:0]        wmask;
    logic [2:0]        cnt, rr_eff, k;
    logic [CORE_W-1:0] owner;
    logic [ID_W-1:0]   inc_id;

    assign links[0]    = '0;
    assign last        = links[NUM_SLOTS];
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy | r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        jsd_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl),
            .i_link (links[g]),
            .o_link (links[g+1])
        );
    end

    always_comb begin
        wmask = '0;
        for (int i = 1; i < MAX_WRK; i++) begin
            if (i < NUM_CORES) wmask[i] = r_mask[i];
        end
        cnt = '0;
        for (int i = 1; i < MAX_WRK; i++) cnt = cnt + 3'(wmask[i]);
        rr_eff = (r_rr >= cnt) ? 3'd0 : r_rr;
        owner  = '0;
        k      = '0;
        for (int i = 1; i < MAX_WRK; i++) begin
            if (wmask[i]) begin
                if (k == rr_eff) owner = CORE_W'(i);
                k = k + 3'd1;
            end
        end
        inc_id = r_next_id + 1'b1;
        if (inc_id == '0) inc_id = {{(ID_W-1){1'b0}}, 1'b1};

        ctl              = '0;
        ctl.has_function = r_req.has_function;
        ctl.job_id       = r_req.job_id;
        ctl.core         = r_req.core;
        ctl.new_id       = r_next_id;
        ctl.new_owner    = owner;

        n_out       = '0;
        n_next_id   = r_next_id;
        n_rr        = r_rr;
        n_qcnt      = r_qcnt;
        n_rcnt      = r_rcnt;

        case (r_req.action)
            ACT_SUBMIT: begin
                if (!r_enable || !r_req.has_function) begin
                    n_out.result_code = RC_REJECT;
                end else if (cnt == '0) begin
                    n_out.result_code = RC_NOWRK;
                end else begin
                    n_rr = rr_eff + 3'd1;
                    if (!last.free_hit) begin
                        n_out.result_code = RC_FULL;
                    end else begin
                        ctl.go_submit     = r_busy;
                        n_out.job_id_out  = r_next_id;
                        n_out.picked_core = owner;
                        n_next_id         = inc_id;
                        n_qcnt            = r_qcnt + 1'b1;
                    end
                end
            end
            ACT_CLAIM: begin
                if (last.claim_hit) begin
                    ctl.go_claim     = r_busy;
                    n_out.job_id_out = last.claim_id;
                    n_qcnt           = r_qcnt - 1'b1;
                    n_rcnt           = r_rcnt + 1'b1;
                end else begin
                    n_out.result_code = RC_REJECT;
                end
            end
            ACT_COMPLETE: begin
                if (last.find_hit && last.find_status == ST_RUNNING
                        && last.find_owner == r_req.core) begin
                    ctl.go_complete = r_busy;
                    n_rcnt          = r_rcnt - 1'b1;
                end else begin
                    n_out.result_code = RC_REJECT;
                end
            end
            ACT_CANCEL: begin
                if (!last.find_hit) begin
                    n_out.result_code = RC_NOWRK;
                end else if (last.find_status == ST_QUEUED) begin
                    ctl.go_cancel = r_busy;
                    n_qcnt        = r_qcnt - 1'b1;
                end else if (last.find_status == ST_RUNNING) begin
                    n_out.result_code = RC_REJECT;
                end
            end
            ACT_QUERY: begin
                n_out.job_status = last.find_hit ? last.find_status : ST_EMPTY;
            end
            default: begin
            end
        endcase

        n_out.queued_count  = (32'(n_qcnt) > 32'd127) ? 7'd127 : CNT_OUT'(n_qcnt);
        n_out.running_count = (32'(n_rcnt) > 32'd127) ? 7'd127 : CNT_OUT'(n_rcnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_mask      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_next_id   <= {{(ID_W-1){1'b0}}, 1'b1};
            r_rr        <= '0;
            r_qcnt      <= '0;
            r_rcnt      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ENABLE:      r_enable <= i_cfg_data[0];
                    CFG_WORKER_MASK: r_mask   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_in_valid && !o_in_stall) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                r_next_id   <= n_next_id;
                r_rr        <= n_rr;
                r_qcnt      <= n_qcnt;
                r_rcnt      <= n_rcnt;
            end
        end
        if (i_in_valid && !o_in_stall) r_req <= i_in_data;
        if (r_busy) r_out <= n_out;
    end

    `JSD_ASSERT(a_busy_one_cycle, i_clk, i_rst_n, r_busy |=> !r_busy, "evaluation held two cycles")
    `JSD_ASSERT(a_out_after_eval, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_busy), "result without evaluation")
    `JSD_NEVER(a_count_bound, i_clk, i_rst_n, 32'(r_qcnt) + 32'(r_rcnt) > NUM_SLOTS, "live counts exceed slots")
    `JSD_NEVER(a_one_go, i_clk, i_rst_n, !$onehot0({ctl.go_submit, ctl.go_claim, ctl.go_complete, ctl.go_cancel}), "several table updates at once")

endmodule

// ===== design/jsd_cell.sv =====
`timescale 1ns / 1ps
module jsd_cell import jsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  t_link i_link,
    output t_link o_link
);

    t_status           r_status, n_status;
    logic [ID_W-1:0]   r_id, n_id;
    logic [CORE_W-1:0] r_owner, n_owner;
    logic              free, claim, find, sel_free, sel_claim, sel_find;

    always_comb begin
        free  = (r_status == ST_EMPTY) || (r_status == ST_DONE) || (r_status == ST_FAILED);
        claim = (r_status == ST_QUEUED) && (r_owner == i_ctl.core);
        find  = (r_status != ST_EMPTY) && (r_id == i_ctl.job_id);
        sel_free  = free  && !i_link.free_hit;
        sel_claim = claim && !i_link.claim_hit;
        sel_find  = find  && !i_link.find_hit;

        o_link.free_hit    = i_link.free_hit | free;
        o_link.claim_hit   = i_link.claim_hit | claim;
        o_link.claim_id    = sel_claim ? r_id : i_link.claim_id;
        o_link.find_hit    = i_link.find_hit | find;
        o_link.find_status = sel_find ? r_status : i_link.find_status;
        o_link.find_owner  = sel_find ? r_owner : i_link.find_owner;

        n_status = r_status;
        n_id     = r_id;
        n_owner  = r_owner;
        if (i_ctl.go_submit && sel_free) begin
            n_status = ST_QUEUED;
            n_id     = i_ctl.new_id;
            n_owner  = i_ctl.new_owner;
        end
        if (i_ctl.go_claim && sel_claim) begin
            n_status = ST_RUNNING;
        end
        if (i_ctl.go_complete && sel_find && r_status == ST_RUNNING
                && r_owner == i_ctl.core) begin
            n_status = i_ctl.has_function ? ST_DONE : ST_FAILED;
        end
        if (i_ctl.go_cancel && sel_find && r_status == ST_QUEUED) begin
            n_status = ST_FAILED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_EMPTY;
        end else begin
            r_status <= n_status;
        end
        r_id    <= n_id;
        r_owner <= n_owner;
    end

endmodule
